// ----- design/fbiq_pkg.sv -----
// Shared types and constants for the fingerprint bin insert/query unit.
// Depends on nothing; every other design file imports it.
`default_nettype none

package fbiq_pkg;

	localparam int FP_W    = 16;
	localparam int BIN_W   = 8;
	localparam int CNT_W   = 4;
	localparam int QDEPTH  = 2;

	typedef enum logic {
		FUNC_QUERY  = 1'b0,
		FUNC_INSERT = 1'b1
	} func_t;

	// One classified operation waiting between front and back.
	typedef struct packed {
		logic [FP_W-1:0]  fp;
		logic [BIN_W-1:0] bin;
		logic             insert;
	} item_t;

	// One result beat, last field in the lowest bits.
	typedef struct packed {
		logic [FP_W-1:0] evicted_value;
		logic            evicted;
		logic            hit;
	} result_t;

endpackage

`default_nettype wire

// ----- design/fbiq_front.sv -----
// Input side: accepts operations, wraps the bin index and classifies the operation.
// Depends on fbiq_pkg.
`default_nettype none

module fbiq_front #(
	parameter int NUM_BINS = 256
) (
	input  wire logic                       s_valid,
	input  wire logic [23:0]                s_data,
	input  wire logic [7:0]                 s_user,
	output logic                            s_ready,
	input  wire logic                       q_full,
	input  wire logic                       clearing,
	output logic                            push,
	output fbiq_pkg::item_t                 item
);
	import fbiq_pkg::*;

	logic [BIN_W-1:0] bin_wrapped;

	// Restoring reduction of the 8-bit index by shifted copies of the bin count.
	always_comb begin
		logic [BIN_W-1:0] r;
		r = s_data[BIN_W-1:0];
		for (int k = BIN_W-1; k >= 0; k--) begin
			if ({24'd0, r} >= (32'(NUM_BINS) << k)) begin
				r = r - BIN_W'(32'(NUM_BINS) << k);
			end
		end
		bin_wrapped = r;
	end

	assign s_ready     = !q_full && !clearing;
	assign push        = s_valid && s_ready;
	assign item.fp     = s_data[BIN_W +: FP_W];
	assign item.bin    = bin_wrapped;
	assign item.insert = (func_t'(s_user[0]) == FUNC_INSERT);

endmodule

`default_nettype wire

// ----- design/fbiq_queue.sv -----
// Two-entry queue that decouples the input side from the bin engine.
// Depends on fbiq_pkg.
`default_nettype none

module fbiq_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire fbiq_pkg::item_t  push_item,
	output logic                  full,
	input  wire logic             pop,
	output logic                  nonempty,
	output fbiq_pkg::item_t       head
);
	import fbiq_pkg::*;

	item_t      ent_q [QDEPTH];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign full     = (cnt_q == 2'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = ent_q[rp_q];

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < 2'(QDEPTH) || pop))
		else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("queue read while empty");

endmodule

`default_nettype wire

// ----- design/fbiq_back.sv -----
// Bin engine: one memory row per bin (slots, fill count, overflow flag), read,
// evaluated, written back on an insert that misses; holds the result register.
// Depends on fbiq_pkg.
`default_nettype none

module fbiq_back #(
	parameter int NUM_BINS = 256,
	parameter int SLOTS    = 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_nonempty,
	input  wire fbiq_pkg::item_t  q_head,
	output logic                  q_pop,
	output logic                  clearing,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output fbiq_pkg::result_t     out_data
);
	import fbiq_pkg::*;

	localparam int AW       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int CNT_LO   = SLOTS * FP_W;
	localparam int FLAG_BIT = CNT_LO + CNT_W;
	localparam int ROW_W    = FLAG_BIT + 1;
	localparam int LV       = (SLOTS > 1) ? $clog2(SLOTS) : 0;
	localparam int TN       = 1 << LV;

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_EVAL, S_TREE, S_WB, S_DONE
	} state_t;

	state_t           state_q;
	item_t            item_q;
	logic [AW-1:0]    clr_q;
	logic [2:0]       lvl_q;
	logic [FP_W-1:0]  tv_q [TN];
	logic [3:0]       ti_q [TN];
	logic             tk_q [TN];
	logic             hit_q;
	logic             ev_q;
	logic [FP_W-1:0]  evv_q;
	logic             out_vld_q;
	result_t          out_q;

	logic [ROW_W-1:0] mem [NUM_BINS];
	logic [ROW_W-1:0] rd_q;

	logic [TN*FP_W-1:0] slots_pad;
	logic [FP_W-1:0]    sv [TN];
	logic [CNT_W-1:0]   cnt;
	logic               flag;
	logic               hit;
	logic               ovf;
	logic               append;
	logic               mem_we;
	logic [AW-1:0]      wa;
	logic [ROW_W-1:0]   wd;
	logic               wslot;
	logic [3:0]         widx;
	logic               out_load;

	assign slots_pad = (TN*FP_W)'(rd_q[CNT_LO-1:0]);
	assign cnt       = rd_q[CNT_LO +: CNT_W];
	assign flag      = rd_q[FLAG_BIT];

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < TN; i++) begin
			sv[i] = slots_pad[i*FP_W +: FP_W];
			if (i < SLOTS && 4'(i) < cnt && sv[i] == item_q.fp) hit = 1'b1;
		end
	end

	// A bin that is exactly full turns overflowed on this same insert.
	assign ovf      = flag || (cnt >= 4'(SLOTS));
	assign append   = item_q.insert && !hit && !ovf;
	assign q_pop    = (state_q == S_IDLE) && q_nonempty;
	assign out_load = (state_q == S_DONE) && (!out_vld_q || out_ready);
	assign clearing = (state_q == S_CLR);

	always_comb begin
		mem_we = 1'b0;
		wa     = AW'(item_q.bin);
		wd     = rd_q;
		wslot  = 1'b0;
		widx   = cnt;
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				wa     = clr_q;
				wd     = '0;
			end
			S_EVAL: begin
				if (append) begin
					mem_we = 1'b1;
					wslot  = 1'b1;
					wd[CNT_LO +: CNT_W] = cnt + 4'd1;
				end
			end
			S_WB: begin
				mem_we       = 1'b1;
				wd[FLAG_BIT] = 1'b1;
				wslot        = tk_q[0];
				widx         = ti_q[0];
			end
			default: begin
			end
		endcase
		for (int i = 0; i < SLOTS; i++) begin
			if (wslot && widx == 4'(i)) wd[i*FP_W +: FP_W] = item_q.fp;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wa] <= wd;
		if (q_pop)  rd_q <= mem[AW'(q_head.bin)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			lvl_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NUM_BINS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_pop) state_q <= S_EVAL;
				end
				S_EVAL: begin
					lvl_q <= '0;
					if (item_q.insert && !hit && ovf) begin
						state_q <= (LV == 0) ? S_WB : S_TREE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_TREE: begin
					lvl_q <= lvl_q + 3'd1;
					if (lvl_q == 3'(LV - 1)) state_q <= S_WB;
				end
				S_WB: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers: operation, result fields and the max-search tree.
	always_ff @(posedge clk) begin
		if (q_pop) item_q <= q_head;
		if (state_q == S_EVAL) begin
			hit_q <= hit;
			ev_q  <= 1'b0;
			evv_q <= '0;
			for (int i = 0; i < TN; i++) begin
				tv_q[i] <= sv[i];
				ti_q[i] <= 4'(i);
				tk_q[i] <= (i < SLOTS) && (4'(i) < cnt) && (sv[i] > item_q.fp);
			end
		end
		// One tree level per cycle; on a tie the lower slot wins.
		if (state_q == S_TREE) begin
			for (int j = 0; j < TN/2; j++) begin
				if (tk_q[2*j+1] && (!tk_q[2*j] || tv_q[2*j+1] > tv_q[2*j])) begin
					tv_q[j] <= tv_q[2*j+1];
					ti_q[j] <= ti_q[2*j+1];
					tk_q[j] <= 1'b1;
				end else begin
					tv_q[j] <= tv_q[2*j];
					ti_q[j] <= ti_q[2*j];
					tk_q[j] <= tk_q[2*j];
				end
			end
		end
		if (state_q == S_WB) begin
			ev_q  <= 1'b1;
			evv_q <= tk_q[0] ? tv_q[0] : item_q.fp;
		end
		if (out_load) begin
			out_q.hit           <= hit_q;
			out_q.evicted       <= ev_q;
			out_q.evicted_value <= evv_q;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("memory written with no operation in flight");
	a_quiet_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !ev_q) |-> evv_q == '0)
		else $error("evicted value nonzero without eviction");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !q_pop)
		else $error("operation started during clearing pass");

endmodule

`default_nettype wire

// ----- design/fingerprint_bin_insert_query_unit.sv -----
// Fingerprint bin insert/query unit: input side, queue and bin engine.
// Depends on fbiq_pkg, fbiq_front, fbiq_queue and fbiq_back.
//
// Usage:
//   Operations enter on the s_axis channel: tuser[0] selects query (0) or
//   insert (1), tdata carries the bin index and the 16-bit fingerprint. Each
//   accepted beat yields exactly one m_axis beat with hit, evicted and the
//   evicted value, in order.
//   Every operation reads the bin's memory row (all slots, fill count and
//   overflow flag) and evaluates it; an insert that misses writes it back.
//   A query, a hit, or an append passes through row read, evaluation and
//   output register load in the engine; an insert that misses on a full or
//   overflowed bin adds the registered largest-value search and a write-back
//   step before the load. The engine works on one operation at a time and
//   takes the next one from the queue only after the previous result is
//   loaded into the output register.
//   A two-entry queue lets the input side keep accepting while the engine
//   works or waits on a stalled receiver; when the receiver holds m_axis_tready
//   low, the engine parks its finished result and the queue fills up.
//   After reset the engine clears every row, one bin per cycle, and
//   s_axis_tready stays low meanwhile.
`default_nettype none

module fingerprint_bin_insert_query_unit #(
	parameter int NUM_BINS = 256,
	parameter int SLOTS    = 15
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // bin_index[7:0], fingerprint[23:8]
	input  wire logic [7:0]  s_axis_tuser,  // func[0], zeros above
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata   // hit[0], evicted[1], evicted_value[17:2]
);
	import fbiq_pkg::*;

	logic    q_full;
	logic    q_nonempty;
	logic    push;
	logic    pop;
	logic    clearing;
	item_t   in_item;
	item_t   head;
	result_t res;

	fbiq_front #(
		.NUM_BINS(NUM_BINS)
	) u_front (
		.s_valid  (s_axis_tvalid),
		.s_data   (s_axis_tdata),
		.s_user   (s_axis_tuser),
		.s_ready  (s_axis_tready),
		.q_full   (q_full),
		.clearing (clearing),
		.push     (push),
		.item     (in_item)
	);

	fbiq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (in_item),
		.full      (q_full),
		.pop       (pop),
		.nonempty  (q_nonempty),
		.head      (head)
	);

	fbiq_back #(
		.NUM_BINS(NUM_BINS),
		.SLOTS   (SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (head),
		.q_pop      (pop),
		.clearing   (clearing),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (res)
	);

	assign m_axis_tdata = {6'd0, res};

endmodule

`default_nettype wire
